// File: hw/rtl/blfpn_pkg.sv
// ----------------------------------------------------------------------------
// blfpn_pkg
// Shared types and constants for the band level floor/peak normalizer.
// ----------------------------------------------------------------------------
package blfpn_pkg;

  localparam int unsigned IN_BANDS  = 2;
  localparam int unsigned E_W       = 23;  // Q15.8 energy
  localparam int unsigned ES_W      = 31;  // Q15.16 energy state
  localparam int unsigned LS_W      = 32;  // Q1.31 level state
  localparam int unsigned LVL_W     = 16;  // Q1.15 level
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIV_STEPS = 15;  // quotient bits below one

  localparam logic [LVL_W-1:0] ONE_Q15 = 16'h8000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_RISE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_RATE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LFLOOR_RISE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LPEAK_DECAY = 3'd4;

  typedef struct packed {
    logic [CFG_W-1:0] floor_rise_rate;
    logic [CFG_W-1:0] peak_decay_factor;
    logic [CFG_W-1:0] average_rate;
    logic [CFG_W-1:0] level_floor_rise_rate;
    logic [CFG_W-1:0] level_peak_decay_factor;
  } cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] relative;
    logic [E_W-1:0]   floor_out;
    logic [E_W-1:0]   peak_out;
    logic [E_W-1:0]   mean_out;
  } lane_res_t;

endpackage

// File: hw/rtl/blfpn_lane.sv
// ----------------------------------------------------------------------------
// blfpn_lane
// One band: floor/peak/mean tracking, level, level tracking and relative
// level, using one shared 32x16 multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
module blfpn_lane import blfpn_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [E_W-1:0]  energy_i,
  input  cfg_t            cfg_i,
  input  logic            ack_i,
  output logic            done_o,
  output lane_res_t       res_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_FL, S_PK, S_MN, S_CHK, S_DIV, S_LF, S_LP, S_RSET, S_DONE
  } state_e;

  state_e            state_q;
  logic [ES_W-1:0]   e_q, efl_q, epk_q, emn_q;
  logic [LS_W-1:0]   lfl_q, lpk_q;
  logic [LS_W:0]     num_q, den_q, rem_q;
  logic [LVL_W-1:0]  quo_q, lvl_q, rel_q;
  logic [3:0]        cnt_q;
  logic              phase_q;

  logic [LS_W-1:0]   mul_a;
  logic [CFG_W-1:0]  mul_b;
  logic [47:0]       prod;
  logic [LS_W-1:0]   step;
  logic [LS_W-1:0]   x_w;
  logic [LS_W+1:0]   rem2;
  logic [LS_W+1:0]   den2;

  assign x_w  = {lvl_q, 16'h0000};
  assign rem2 = {rem_q, 1'b0};
  assign den2 = {1'b0, den_q};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_FL: begin
        mul_a = LS_W'(e_q - efl_q);
        mul_b = cfg_i.floor_rise_rate;
      end
      S_PK: begin
        mul_a = LS_W'(epk_q);
        mul_b = cfg_i.peak_decay_factor;
      end
      S_MN: begin
        mul_a = (e_q >= emn_q) ? LS_W'(e_q - emn_q) : LS_W'(emn_q - e_q);
        mul_b = cfg_i.average_rate;
      end
      S_LF: begin
        mul_a = x_w - lfl_q;
        mul_b = cfg_i.level_floor_rise_rate;
      end
      S_LP: begin
        mul_a = lpk_q;
        mul_b = cfg_i.level_peak_decay_factor;
      end
      default: ;
    endcase
  end

  assign prod = 48'(mul_a) * 48'(mul_b);
  assign step = prod[47:16];

  // sequencer, tracked state and divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      e_q     <= '0;
      efl_q   <= '0;
      epk_q   <= '0;
      emn_q   <= '0;
      lfl_q   <= '0;
      lpk_q   <= '0;
      num_q   <= '0;
      den_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      lvl_q   <= '0;
      rel_q   <= '0;
      cnt_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            e_q     <= {energy_i, 8'h00};
            state_q <= S_FL;
          end
        end
        S_FL: begin
          efl_q   <= (e_q < efl_q) ? e_q : ES_W'(efl_q + step[ES_W-1:0]);
          state_q <= S_PK;
        end
        S_PK: begin
          epk_q   <= (e_q > epk_q) ? e_q : step[ES_W-1:0];
          state_q <= S_MN;
        end
        S_MN: begin
          emn_q   <= (e_q >= emn_q) ? ES_W'(emn_q + step[ES_W-1:0])
                                    : ES_W'(emn_q - step[ES_W-1:0]);
          num_q   <= (e_q > efl_q) ? (LS_W+1)'(e_q - efl_q) : '0;
          den_q   <= (LS_W+1)'(efl_q) + (LS_W+1)'(epk_q);
          phase_q <= 1'b0;
          state_q <= S_CHK;
        end
        // zero divisor gives 0, level of one or more saturates
        S_CHK: begin
          if (den_q == '0) begin
            quo_q <= '0;
            cnt_q <= '0;
          end else if (num_q >= den_q) begin
            quo_q <= ONE_Q15;
            cnt_q <= '0;
          end else begin
            rem_q <= num_q;
            quo_q <= '0;
            cnt_q <= 4'(DIV_STEPS);
          end
          state_q <= S_DIV;
        end
        // restoring division, one quotient bit a cycle
        S_DIV: begin
          if (cnt_q == '0) begin
            if (phase_q) begin
              rel_q   <= quo_q;
              state_q <= S_DONE;
            end else begin
              lvl_q   <= quo_q;
              state_q <= S_LF;
            end
          end else begin
            if (rem2 >= den2) begin
              rem_q <= (LS_W+1)'(rem2 - den2);
              quo_q <= {quo_q[LVL_W-2:0], 1'b1};
            end else begin
              rem_q <= rem2[LS_W:0];
              quo_q <= {quo_q[LVL_W-2:0], 1'b0};
            end
            cnt_q <= cnt_q - 4'd1;
          end
        end
        S_LF: begin
          lfl_q   <= (x_w < lfl_q) ? x_w : LS_W'(lfl_q + step);
          state_q <= S_LP;
        end
        S_LP: begin
          lpk_q   <= (x_w > lpk_q) ? x_w : step;
          state_q <= S_RSET;
        end
        S_RSET: begin
          num_q   <= (x_w > lfl_q) ? (LS_W+1)'(x_w - lfl_q) : '0;
          den_q   <= (LS_W+1)'(lfl_q) + (LS_W+1)'(lpk_q);
          phase_q <= 1'b1;
          state_q <= S_CHK;
        end
        S_DONE: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o         = (state_q == S_DONE);
  assign res_o.level    = lvl_q;
  assign res_o.relative = rel_q;
  assign res_o.floor_out = efl_q[ES_W-1:8];
  assign res_o.peak_out  = epk_q[ES_W-1:8];
  assign res_o.mean_out  = emn_q[ES_W-1:8];

endmodule

// File: hw/rtl/band_level_floor_peak_normalizer_top.sv
// ----------------------------------------------------------------------------
// band_level_floor_peak_normalizer_top
// Per-band floor/peak/mean trackers and level normalizer, one lane per band.
// ----------------------------------------------------------------------------
// Flow: each lane runs its tracker updates and two serial divisions of up to
//   15 quotient bits each; the next request is taken only once the previous
//   result is in the output register, which waits while the receiver stalls.
// Reset: all tracker state clears to zero, registers take their defaults.
module band_level_floor_peak_normalizer_top import blfpn_pkg::*; #(
  parameter int unsigned NUM_BANDS = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [E_W-1:0]       low_energy_i,
  input  logic [E_W-1:0]       high_energy_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LVL_W-1:0]     low_level_o,
  output logic [LVL_W-1:0]     low_relative_o,
  output logic [LVL_W-1:0]     high_level_o,
  output logic [LVL_W-1:0]     high_relative_o,
  output logic [E_W-1:0]       low_floor_out_o,
  output logic [E_W-1:0]       low_peak_out_o,
  output logic [E_W-1:0]       low_mean_out_o,
  output logic [E_W-1:0]       high_floor_out_o,
  output logic [E_W-1:0]       high_peak_out_o,
  output logic [E_W-1:0]       high_mean_out_o
);

  localparam int unsigned NUM_LANES = (NUM_BANDS < IN_BANDS) ? NUM_BANDS : IN_BANDS;

  cfg_t      cfg_q;
  logic      busy_q;
  logic      out_valid_q;
  lane_res_t res_q [IN_BANDS];

  logic      accept;
  logic      load;
  logic      all_done;
  logic [IN_BANDS-1:0] lane_done;
  lane_res_t lane_res [IN_BANDS];
  logic [E_W-1:0] band_energy [IN_BANDS];

  assign band_energy[0] = low_energy_i;
  assign band_energy[1] = high_energy_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.floor_rise_rate         <= 16'd65;
      cfg_q.peak_decay_factor       <= 16'd65470;
      cfg_q.average_rate            <= 16'd5958;
      cfg_q.level_floor_rise_rate   <= 16'd163;
      cfg_q.level_peak_decay_factor <= 16'd65470;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FLOOR_RISE:  cfg_q.floor_rise_rate         <= cfg_data_i;
        REG_PEAK_DECAY:  cfg_q.peak_decay_factor       <= cfg_data_i;
        REG_AVG_RATE:    cfg_q.average_rate            <= cfg_data_i;
        REG_LFLOOR_RISE: cfg_q.level_floor_rise_rate   <= cfg_data_i;
        REG_LPEAK_DECAY: cfg_q.level_peak_decay_factor <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // band lanes; absent bands report done with zero results
  for (genvar b = 0; b < IN_BANDS; b++) begin : g_band
    if (b < NUM_LANES) begin : g_lane
      blfpn_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .start_i  (accept),
        .energy_i (band_energy[b]),
        .cfg_i    (cfg_q),
        .ack_i    (load),
        .done_o   (lane_done[b]),
        .res_o    (lane_res[b])
      );
    end else begin : g_none
      assign lane_done[b] = 1'b1;
      assign lane_res[b]  = '0;
    end
  end

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign all_done   = &lane_done;
  assign load       = busy_q && all_done && (!out_valid_q || out_ready_i);

  // merge: collect lane results into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < IN_BANDS; i++) begin
        res_q[i] <= lane_res[i];
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign low_level_o      = res_q[0].level;
  assign low_relative_o   = res_q[0].relative;
  assign low_floor_out_o  = res_q[0].floor_out;
  assign low_peak_out_o   = res_q[0].peak_out;
  assign low_mean_out_o   = res_q[0].mean_out;
  assign high_level_o     = res_q[1].level;
  assign high_relative_o  = res_q[1].relative;
  assign high_floor_out_o = res_q[1].floor_out;
  assign high_peak_out_o  = res_q[1].peak_out;
  assign high_mean_out_o  = res_q[1].mean_out;

  // a request in flight blocks the next one
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request accepted while previous still in flight");

  // levels never exceed one
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (low_level_o <= ONE_Q15) && (high_level_o <= ONE_Q15) &&
                    (low_relative_o <= ONE_Q15) && (high_relative_o <= ONE_Q15))
    else $error("level above one");

  // results are only merged for a request in flight
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o && !busy_q)
    else $error("merge without matching request");

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the band level floor/peak normalizer: a queue-fed
// driver, a monitor and a bit-exact predictor of the per-band trackers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import blfpn_pkg::*;

  localparam int unsigned MAX_CYCLES = 400000;
  localparam int unsigned N_REGS     = 5;

  typedef struct packed {
    logic [E_W-1:0] low_e;
    logic [E_W-1:0] high_e;
  } frame_t;

  typedef struct packed {
    lane_res_t lo;
    lane_res_t hi;
  } levels_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [E_W-1:0] low_energy_i = '0;
  logic [E_W-1:0] high_energy_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [LVL_W-1:0] low_level_o, low_relative_o, high_level_o, high_relative_o;
  logic [E_W-1:0] low_floor_out_o, low_peak_out_o, low_mean_out_o;
  logic [E_W-1:0] high_floor_out_o, high_peak_out_o, high_mean_out_o;

  band_level_floor_peak_normalizer_top dut (.*);

  // predictor state, per band
  logic [63:0] e_floor [2] = '{default: '0};
  logic [63:0] e_peak [2]  = '{default: '0};
  logic [63:0] e_mean [2]  = '{default: '0};
  logic [63:0] l_floor [2] = '{default: '0};
  logic [63:0] l_peak [2]  = '{default: '0};
  logic [63:0] rates [N_REGS];

  frame_t  pending_frames [$];
  levels_t expected_levels [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;       // no idling stretch
  int hold_off = 0;       // receiver long stall counter
  int hold_reqs = 0;      // long stalls asked for
  int hold_seen = 0;      // long stalls started
  bit in_took = 1'b0;     // request accepted at the last rising edge

  function automatic logic [63:0] follow_floor(logic [63:0] fl, logic [63:0] x,
                                               logic [63:0] r);
    if (x < fl) return x;
    return fl + (((x - fl) * r) >> 16);
  endfunction

  function automatic logic [63:0] follow_peak(logic [63:0] pk, logic [63:0] x,
                                              logic [63:0] d);
    if (x > pk) return x;
    return (pk * d) >> 16;
  endfunction

  function automatic logic [63:0] place(logic [63:0] x, logic [63:0] fl,
                                        logic [63:0] pk);
    logic [63:0] num, den, q;
    num = (x > fl) ? x - fl : 64'd0;
    den = fl + pk;
    if (den == 64'd0) return 64'd0;
    q = (num << 15) / den;
    return (q > 64'd32768) ? 64'd32768 : q;
  endfunction

  function automatic lane_res_t track_band(int b, logic [E_W-1:0] energy);
    logic [63:0] e, fl, pk, mn, lvl, lv, lfl, lpk, rel;
    lane_res_t r;
    e  = 64'(energy) << 8;
    fl = follow_floor(e_floor[b], e, rates[REG_FLOOR_RISE]);
    pk = follow_peak(e_peak[b], e, rates[REG_PEAK_DECAY]);
    mn = e_mean[b];
    if (e >= mn) mn = mn + (((e - mn) * rates[REG_AVG_RATE]) >> 16);
    else mn = mn - (((mn - e) * rates[REG_AVG_RATE]) >> 16);
    lvl = place(e, fl, pk);
    lv  = lvl << 16;
    lfl = follow_floor(l_floor[b], lv, rates[REG_LFLOOR_RISE]);
    lpk = follow_peak(l_peak[b], lv, rates[REG_LPEAK_DECAY]);
    rel = place(lv, lfl, lpk);
    e_floor[b] = fl & 64'h7FFF_FFFF;
    e_peak[b]  = pk & 64'h7FFF_FFFF;
    e_mean[b]  = mn & 64'h7FFF_FFFF;
    l_floor[b] = lfl & 64'hFFFF_FFFF;
    l_peak[b]  = lpk & 64'hFFFF_FFFF;
    r.level     = lvl[15:0];
    r.relative  = rel[15:0];
    r.floor_out = e_floor[b][30:8];
    r.peak_out  = e_peak[b][30:8];
    r.mean_out  = e_mean[b][30:8];
    return r;
  endfunction

  // clock and cycle limit
  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // driver: offers the next request at the falling edge once the last is taken
  always @(negedge clk_i) begin
    frame_t f;
    bit free;
    free = !in_valid_i || in_took;
    if (free) begin
      if (pending_frames.size() > 0 && (quiet || $urandom_range(99) >= 18)) begin
        f = pending_frames.pop_front();
        low_energy_i  <= f.low_e;
        high_energy_i <= f.high_e;
        in_valid_i    <= 1'b1;
      end else begin
        in_valid_i    <= 1'b0;
      end
    end
  end

  // predictor: runs at each accept
  always @(posedge clk_i) begin
    levels_t x;
    in_took <= in_valid_i && in_ready_o && rst_ni;
    if (in_valid_i && in_ready_o && rst_ni) begin
      x.lo = track_band(0, low_energy_i);
      x.hi = track_band(1, high_energy_i);
      expected_levels.push_back(x);
    end
  end

  // receiver readiness, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen   <= hold_reqs;
      hold_off    <= 600;
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(99) >= 18);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    levels_t x, got;
    if (out_valid_o && out_ready_i) begin
      got.lo = '{low_level_o, low_relative_o, low_floor_out_o, low_peak_out_o,
                 low_mean_out_o};
      got.hi = '{high_level_o, high_relative_o, high_floor_out_o,
                 high_peak_out_o, high_mean_out_o};
      if (expected_levels.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        x = expected_levels.pop_front();
        if (got.lo.level !== x.lo.level)
          $display("%0t low_level exp %0d got %0d", $time, x.lo.level, got.lo.level);
        if (got.lo.relative !== x.lo.relative)
          $display("%0t low_relative exp %0d got %0d", $time, x.lo.relative,
                   got.lo.relative);
        if (got.lo.floor_out !== x.lo.floor_out)
          $display("%0t low_floor exp %0d got %0d", $time, x.lo.floor_out,
                   got.lo.floor_out);
        if (got.lo.peak_out !== x.lo.peak_out)
          $display("%0t low_peak exp %0d got %0d", $time, x.lo.peak_out,
                   got.lo.peak_out);
        if (got.lo.mean_out !== x.lo.mean_out)
          $display("%0t low_mean exp %0d got %0d", $time, x.lo.mean_out,
                   got.lo.mean_out);
        if (got.hi.level !== x.hi.level)
          $display("%0t high_level exp %0d got %0d", $time, x.hi.level, got.hi.level);
        if (got.hi.relative !== x.hi.relative)
          $display("%0t high_relative exp %0d got %0d", $time, x.hi.relative,
                   got.hi.relative);
        if (got.hi.floor_out !== x.hi.floor_out)
          $display("%0t high_floor exp %0d got %0d", $time, x.hi.floor_out,
                   got.hi.floor_out);
        if (got.hi.peak_out !== x.hi.peak_out)
          $display("%0t high_peak exp %0d got %0d", $time, x.hi.peak_out,
                   got.hi.peak_out);
        if (got.hi.mean_out !== x.hi.mean_out)
          $display("%0t high_mean exp %0d got %0d", $time, x.hi.mean_out,
                   got.hi.mean_out);
        if (got !== x) errors++;
      end
    end
  end

  // wait until the block has drained, then some latency on top
  task automatic drain();
    while (pending_frames.size() > 0 || in_valid_i || expected_levels.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // register write at a falling edge, taken at the next rising edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < N_REGS) rates[idx] = 64'(val);
  endtask

  function automatic logic [E_W-1:0] rand_energy();
    case ($urandom_range(5))
      0: return '0;
      1: return {E_W{1'b1}};
      2: return E_W'($urandom_range(4095));
      default: return E_W'($urandom);
    endcase
  endfunction

  task automatic add_random(int n);
    frame_t f;
    repeat (n) begin
      f.low_e  = rand_energy();
      f.high_e = rand_energy();
      pending_frames.push_back(f);
    end
  endtask

  initial begin
    frame_t f;
    rates[REG_FLOOR_RISE]  = 65;
    rates[REG_PEAK_DECAY]  = 65470;
    rates[REG_AVG_RATE]    = 5958;
    rates[REG_LFLOOR_RISE] = 163;
    rates[REG_LPEAK_DECAY] = 65470;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero divisor first, then extremes and floor/peak snaps
    f = '{23'd0, 23'd0};                 pending_frames.push_back(f);
    f = '{23'd0, 23'd0};                 pending_frames.push_back(f);
    f = '{{E_W{1'b1}}, 23'd1};           pending_frames.push_back(f);
    f = '{23'd1, {E_W{1'b1}}};           pending_frames.push_back(f);
    f = '{{E_W{1'b1}}, {E_W{1'b1}}};     pending_frames.push_back(f);
    f = '{23'h2AAAAA, 23'h555555};       pending_frames.push_back(f);
    f = '{23'h555555, 23'h2AAAAA};       pending_frames.push_back(f);
    f = '{23'd100, 23'd100};             pending_frames.push_back(f);
    f = '{23'd0, 23'd0};                 pending_frames.push_back(f);
    f = '{23'd5000, 23'd3};              pending_frames.push_back(f);
    drain();

    // extremes of every register plus an out-of-range index
    write_reg(REG_FLOOR_RISE, 16'hFFFF);
    write_reg(REG_PEAK_DECAY, 16'h0000);
    write_reg(REG_AVG_RATE, 16'hFFFF);
    write_reg(REG_LFLOOR_RISE, 16'hFFFF);
    write_reg(REG_LPEAK_DECAY, 16'h0000);
    write_reg(3'd7, 16'h1234);
    add_random(10);
    drain();
    write_reg(REG_FLOOR_RISE, 16'h0000);
    write_reg(REG_PEAK_DECAY, 16'hFFFF);
    write_reg(REG_AVG_RATE, 16'h0000);
    write_reg(REG_LFLOOR_RISE, 16'h0000);
    write_reg(REG_LPEAK_DECAY, 16'hFFFF);
    add_random(10);
    drain();

    // back to defaults: long stretch without idling, then a receiver hold-off
    write_reg(REG_FLOOR_RISE, 16'd65);
    write_reg(REG_PEAK_DECAY, 16'd65470);
    write_reg(REG_AVG_RATE, 16'd5958);
    write_reg(REG_LFLOOR_RISE, 16'd163);
    write_reg(REG_LPEAK_DECAY, 16'd65470);
    quiet = 1'b1;
    add_random(80);
    drain();
    quiet = 1'b0;
    hold_reqs = hold_reqs + 1;
    add_random(120);
    drain();

    // random register settings
    repeat (3) begin
      for (int i = 0; i < N_REGS; i++)
        write_reg(CFG_IDX_W'(i), CFG_W'($urandom));
      add_random(80);
      drain();
    end

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/blfpn_pkg.sv
hw/rtl/blfpn_lane.sv
hw/rtl/band_level_floor_peak_normalizer_top.sv
bench/tb_top.sv
